FILE: hw/rtl/xcfp_pkg.sv
// Shared types and constants for the XOR-checked frame parser.
package xcfp_pkg;

	localparam int unsigned BYTE_W          = 8;
	localparam int unsigned POS_W           = 8;
	localparam int unsigned ERR_W           = 3;
	localparam int unsigned HEADER_BYTES    = 4;
	localparam int unsigned MIN_FRAME_BYTES = 5;
	localparam logic [BYTE_W-1:0] START_BYTE_RESET = 8'hAA;

	typedef enum logic [ERR_W-1:0] {
		ERR_OK       = 3'd0,
		ERR_SHORT    = 3'd1,
		ERR_START    = 3'd2,
		ERR_LENGTH   = 3'd3,
		ERR_CHECKSUM = 3'd4
	} err_code_t;

	typedef enum logic {
		KIND_PAYLOAD = 1'b0,
		KIND_VERDICT = 1'b1
	} result_kind_t;

	typedef struct packed {
		logic [BYTE_W-1:0] data_byte;
		logic              last_byte;
	} in_item_t;

	typedef struct packed {
		result_kind_t      result_kind;
		logic [BYTE_W-1:0] payload_value;
		logic [POS_W-1:0]  payload_position;
		logic              frame_good;
		err_code_t         error_code;
		logic [BYTE_W-1:0] message_id;
		logic [BYTE_W-1:0] command_code;
		logic [BYTE_W-1:0] payload_length;
		logic [BYTE_W-1:0] first_payload;
		logic              has_first_payload;
	} result_t;

endpackage

FILE: hw/rtl/xcfp_byte_if.sv
// Input byte channel: valid/ready with data byte and last flag.
interface xcfp_byte_if;
	logic                          valid;
	logic                          ready;
	logic [xcfp_pkg::BYTE_W-1:0]   data_byte;
	logic                          last_byte;

	modport source(output valid, output data_byte, output last_byte, input ready);
	modport sink(input valid, input data_byte, input last_byte, output ready);
endinterface

FILE: hw/rtl/xcfp_cfg_if.sv
// Configuration write channel for the expected start byte.
interface xcfp_cfg_if;
	logic                          valid;
	logic                          ready;
	logic [xcfp_pkg::BYTE_W-1:0]   start_byte;

	modport source(output valid, output start_byte, input ready);
	modport sink(input valid, input start_byte, output ready);
endinterface

FILE: hw/rtl/xcfp_result_if.sv
// Result channel: passed payload bytes and end-of-buffer verdicts.
interface xcfp_result_if;
	logic                          valid;
	logic                          ready;
	logic                          result_kind;
	logic [xcfp_pkg::BYTE_W-1:0]   payload_value;
	logic [xcfp_pkg::POS_W-1:0]    payload_position;
	logic                          frame_good;
	logic [xcfp_pkg::ERR_W-1:0]    error_code;
	logic [xcfp_pkg::BYTE_W-1:0]   message_id;
	logic [xcfp_pkg::BYTE_W-1:0]   command_code;
	logic [xcfp_pkg::BYTE_W-1:0]   payload_length;
	logic [xcfp_pkg::BYTE_W-1:0]   first_payload;
	logic                          has_first_payload;

	modport source(output valid, output result_kind, output payload_value,
		output payload_position, output frame_good, output error_code,
		output message_id, output command_code, output payload_length,
		output first_payload, output has_first_payload, input ready);
	modport sink(input valid, input result_kind, input payload_value,
		input payload_position, input frame_good, input error_code,
		input message_id, input command_code, input payload_length,
		input first_payload, input has_first_payload, output ready);
endinterface

FILE: hw/rtl/xcfp_in_reg.sv
// Input register stage holding one received byte.
module xcfp_in_reg (
	input  logic              clk,
	input  logic              arst_n,
	xcfp_byte_if.sink         rx,
	input  logic              advance,
	output logic              valid_s1,
	output xcfp_pkg::in_item_t item_s1
);

	logic take;

	assign rx.ready = !valid_s1 || advance;
	assign take     = rx.valid && rx.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rx.ready) begin
			valid_s1 <= rx.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			item_s1.data_byte <= rx.data_byte;
			item_s1.last_byte <= rx.last_byte;
		end
	end

endmodule

FILE: hw/rtl/xcfp_parse.sv
// Frame state, header capture, running XOR and result formation.
module xcfp_parse #(
	parameter int unsigned MAX_BUFFER_BYTES = 512
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          valid_s1,
	input  xcfp_pkg::in_item_t            item_s1,
	input  logic [xcfp_pkg::BYTE_W-1:0]   start_byte,
	input  logic                          out_free,
	output logic                          advance,
	output logic                          load,
	output xcfp_pkg::result_t             result
);

	localparam int unsigned CNT_W = $clog2(MAX_BUFFER_BYTES + 1);
	localparam logic [CNT_W-1:0] HDR     = CNT_W'(xcfp_pkg::HEADER_BYTES);
	localparam logic [CNT_W-1:0] MIN_LEN = CNT_W'(xcfp_pkg::MIN_FRAME_BYTES - 1);
	localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_BUFFER_BYTES);

	logic [CNT_W-1:0]            count_q;
	logic                        start_ok_q;
	logic [xcfp_pkg::BYTE_W-1:0] msg_id_q;
	logic [xcfp_pkg::BYTE_W-1:0] cmd_q;
	logic [xcfp_pkg::BYTE_W-1:0] len_q;
	logic [xcfp_pkg::BYTE_W-1:0] xor_q;
	logic [xcfp_pkg::BYTE_W-1:0] first_q;

	logic                        start_ok_d;
	logic [xcfp_pkg::BYTE_W-1:0] msg_id_d;
	logic [xcfp_pkg::BYTE_W-1:0] cmd_d;
	logic [xcfp_pkg::BYTE_W-1:0] len_d;
	logic [xcfp_pkg::BYTE_W-1:0] xor_d;
	logic [xcfp_pkg::BYTE_W-1:0] first_d;
	logic [CNT_W-1:0]            count_d;
	logic [CNT_W-1:0]            frame_end;
	logic [CNT_W-1:0]            pay_pos;
	logic [xcfp_pkg::BYTE_W-1:0] b;
	logic                        is_payload;
	logic                        in_header;
	logic                        produces;
	xcfp_pkg::err_code_t         err;

	assign b         = item_s1.data_byte;
	assign in_header = count_q < HDR;
	assign frame_end = CNT_W'(len_q) + HDR;
	assign pay_pos   = count_q - HDR;

	always_comb begin
		start_ok_d = start_ok_q;
		msg_id_d   = msg_id_q;
		cmd_d      = cmd_q;
		len_d      = len_q;
		xor_d      = xor_q;
		first_d    = first_q;
		is_payload = 1'b0;
		if (count_q == '0) begin
			start_ok_d = (b == start_byte);
			xor_d      = b;
		end else if (in_header) begin
			if (count_q == CNT_W'(1)) begin
				msg_id_d = b;
			end else if (count_q == CNT_W'(2)) begin
				cmd_d = b;
			end else begin
				len_d = b;
			end
			xor_d = xor_q ^ b;
		end else if (count_q < frame_end) begin
			is_payload = 1'b1;
			xor_d      = xor_q ^ b;
			if (count_q == HDR) begin
				first_d = b;
			end
		end
	end

	assign count_d = (count_q < CNT_MAX) ? count_q + CNT_W'(1) : count_q;

	always_comb begin
		if (count_q < MIN_LEN) begin
			err = xcfp_pkg::ERR_SHORT;
		end else if (!start_ok_q) begin
			err = xcfp_pkg::ERR_START;
		end else if (count_q != frame_end) begin
			err = xcfp_pkg::ERR_LENGTH;
		end else if (b != xor_q) begin
			err = xcfp_pkg::ERR_CHECKSUM;
		end else begin
			err = xcfp_pkg::ERR_OK;
		end
	end

	assign produces = item_s1.last_byte || is_payload;
	assign advance  = valid_s1 && (out_free || !produces);
	assign load     = advance && produces;

	always_comb begin
		result = '0;
		if (item_s1.last_byte) begin
			result.result_kind       = xcfp_pkg::KIND_VERDICT;
			result.frame_good        = (err == xcfp_pkg::ERR_OK);
			result.error_code        = err;
			result.message_id        = msg_id_d;
			result.command_code      = cmd_d;
			result.payload_length    = len_d;
			result.first_payload     = first_d;
			result.has_first_payload = (len_d != '0) && !in_header;
		end else begin
			result.result_kind      = xcfp_pkg::KIND_PAYLOAD;
			result.payload_value    = b;
			result.payload_position = pay_pos[xcfp_pkg::POS_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= '0;
			start_ok_q <= 1'b0;
			msg_id_q   <= '0;
			cmd_q      <= '0;
			len_q      <= '0;
			xor_q      <= '0;
			first_q    <= '0;
		end else if (advance) begin
			if (item_s1.last_byte) begin
				count_q    <= '0;
				start_ok_q <= 1'b0;
				msg_id_q   <= '0;
				cmd_q      <= '0;
				len_q      <= '0;
				xor_q      <= '0;
				first_q    <= '0;
			end else begin
				count_q    <= count_d;
				start_ok_q <= start_ok_d;
				msg_id_q   <= msg_id_d;
				cmd_q      <= cmd_d;
				len_q      <= len_d;
				xor_q      <= xor_d;
				first_q    <= first_d;
			end
		end
	end

endmodule

FILE: hw/rtl/xcfp_out_reg.sv
// Output register driving the result channel.
module xcfp_out_reg (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              load,
	input  xcfp_pkg::result_t result,
	output logic              out_free,
	xcfp_result_if.source     res
);

	xcfp_pkg::result_t res_q;
	logic              valid_q;

	assign out_free = !valid_q || res.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (out_free) begin
			valid_q <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= result;
		end
	end

	assign res.valid             = valid_q;
	assign res.result_kind       = res_q.result_kind;
	assign res.payload_value     = res_q.payload_value;
	assign res.payload_position  = res_q.payload_position;
	assign res.frame_good        = res_q.frame_good;
	assign res.error_code        = res_q.error_code;
	assign res.message_id        = res_q.message_id;
	assign res.command_code      = res_q.command_code;
	assign res.payload_length    = res_q.payload_length;
	assign res.first_payload     = res_q.first_payload;
	assign res.has_first_payload = res_q.has_first_payload;

endmodule

FILE: hw/rtl/xor_checked_frame_parser.sv
// Top level of the XOR-checked frame parser.
//
// Takes one buffer byte per cycle (last_byte flags the final one) and parses
// start byte, message id, command, length, payload and XOR checksum. Each
// payload byte is passed out as a transfer with result_kind 0; the flagged
// last byte yields one verdict transfer (too short, bad start, length
// mismatch, checksum, ok) with the captured header and first payload byte,
// and the frame state is then cleared. Header, checksum and trailing bytes
// give no transfer. A byte is accepted every cycle unless the input stalls. Its
// result passes an input register, the parse logic and an output register: it
// is loaded into the output register when the parse stage advances, and is
// offered on res from then on. Input stalls only when a waiting result is not
// taken.
// The byte count saturates at MAX_BUFFER_BYTES. Write start_byte (reset 0xAA)
// only while no buffer is in progress.
module xor_checked_frame_parser #(
	parameter int unsigned MAX_BUFFER_BYTES = 512
) (
	input  logic          clk,
	input  logic          arst_n,
	xcfp_byte_if.sink     rx,
	xcfp_cfg_if.sink      cfg,
	xcfp_result_if.source res
);

	logic                        valid_s1;
	xcfp_pkg::in_item_t          item_s1;
	logic                        advance;
	logic                        load;
	logic                        out_free;
	xcfp_pkg::result_t           result;
	logic [xcfp_pkg::BYTE_W-1:0] start_byte_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_byte_q <= xcfp_pkg::START_BYTE_RESET;
		end else if (cfg.valid) begin
			start_byte_q <= cfg.start_byte;
		end
	end

	xcfp_in_reg u_in_reg (
		.clk      (clk),
		.arst_n   (arst_n),
		.rx       (rx),
		.advance  (advance),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	xcfp_parse #(
		.MAX_BUFFER_BYTES (MAX_BUFFER_BYTES)
	) u_parse (
		.clk        (clk),
		.arst_n     (arst_n),
		.valid_s1   (valid_s1),
		.item_s1    (item_s1),
		.start_byte (start_byte_q),
		.out_free   (out_free),
		.advance    (advance),
		.load       (load),
		.result     (result)
	);

	xcfp_out_reg u_out_reg (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (load),
		.result   (result),
		.out_free (out_free),
		.res      (res)
	);

endmodule

FILE: sim/xor_checked_frame_parser_tb.sv
// Self-checking testbench for the XOR-checked frame parser: directed and random buffers.
`timescale 1ns / 100ps

module xor_checked_frame_parser_tb;

	typedef logic [xcfp_pkg::BYTE_W-1:0] byte_t;

	localparam int unsigned MAX_BUF        = 512;
	localparam int unsigned WATCHDOG_LIMIT = 4000;
	localparam int unsigned DRAIN_CYCLES   = 6;
	localparam int unsigned HOLD_OFF_LEN   = 300;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	xcfp_byte_if   rx();
	xcfp_cfg_if    cfg();
	xcfp_result_if res();

	xor_checked_frame_parser #(
		.MAX_BUFFER_BYTES(MAX_BUF)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.rx(rx),
		.cfg(cfg),
		.res(res)
	);

	byte_t             frame_bytes[$];
	xcfp_pkg::result_t outputs_due[$];

	int unsigned send_idle_pct = 0;
	int unsigned recv_idle_pct = 0;
	int unsigned hold_off_len  = 0;
	int unsigned stall_cycles  = 0;
	int unsigned mismatches    = 0;
	int unsigned bytes_sent    = 0;
	int unsigned payloads_seen = 0;
	int unsigned verdicts_seen[5] = '{0, 0, 0, 0, 0};

	byte_t       p_start_cfg = xcfp_pkg::START_BYTE_RESET;
	int unsigned p_count     = 0;
	logic        p_start_ok  = 1'b0;
	byte_t       p_msg_id    = '0;
	byte_t       p_cmd       = '0;
	byte_t       p_len       = '0;
	byte_t       p_xor       = '0;
	byte_t       p_first     = '0;

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic void clear_parse_state();
		p_count    = 0;
		p_start_ok = 1'b0;
		p_msg_id   = '0;
		p_cmd      = '0;
		p_len      = '0;
		p_xor      = '0;
		p_first    = '0;
	endfunction

	function automatic void parse_rx_byte(input byte_t b, input logic last);
		int unsigned         pos;
		int unsigned         offset;
		logic                is_payload;
		xcfp_pkg::result_t   r;
		xcfp_pkg::err_code_t err;
		pos        = p_count;
		offset     = pos - xcfp_pkg::HEADER_BYTES;
		is_payload = 1'b0;
		if (pos == 0) begin
			p_start_ok = (b == p_start_cfg);
			p_xor      = b;
		end else if (pos < xcfp_pkg::HEADER_BYTES) begin
			case (pos)
				1: p_msg_id = b;
				2: p_cmd    = b;
				default: p_len = b;
			endcase
			p_xor ^= b;
		end else if (pos < xcfp_pkg::HEADER_BYTES + p_len) begin
			is_payload = 1'b1;
			if (pos == xcfp_pkg::HEADER_BYTES)
				p_first = b;
		end
		if (p_count < MAX_BUF)
			p_count++;
		r = '0;
		if (last) begin
			if (pos + 1 < xcfp_pkg::MIN_FRAME_BYTES)
				err = xcfp_pkg::ERR_SHORT;
			else if (!p_start_ok)
				err = xcfp_pkg::ERR_START;
			else if (pos != xcfp_pkg::HEADER_BYTES + p_len)
				err = xcfp_pkg::ERR_LENGTH;
			else if (b != p_xor)
				err = xcfp_pkg::ERR_CHECKSUM;
			else
				err = xcfp_pkg::ERR_OK;
			r.result_kind       = xcfp_pkg::KIND_VERDICT;
			r.frame_good        = (err == xcfp_pkg::ERR_OK);
			r.error_code        = err;
			r.message_id        = p_msg_id;
			r.command_code      = p_cmd;
			r.payload_length    = p_len;
			r.first_payload     = p_first;
			r.has_first_payload = (p_len != 0) && (pos >= xcfp_pkg::HEADER_BYTES);
			outputs_due = {outputs_due, r};
			clear_parse_state();
		end else if (is_payload) begin
			p_xor ^= b;
			r.result_kind      = xcfp_pkg::KIND_PAYLOAD;
			r.payload_value    = b;
			r.payload_position = offset[xcfp_pkg::POS_W-1:0];
			outputs_due = {outputs_due, r};
		end
	endfunction

	function automatic void check_field(input string name, input logic [7:0] want,
			input logic [7:0] got);
		if (got !== want) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, want, got);
			mismatches++;
		end
	endfunction

	always @(negedge clk) begin
		xcfp_pkg::result_t want;
		if (res.valid === 1'b1 && res.ready === 1'b1) begin
			if (outputs_due.size() == 0) begin
				$error("result_kind %0d transfer with nothing outstanding", res.result_kind);
				mismatches++;
			end else begin
				want = outputs_due.pop_front();
				check_field("result_kind", want.result_kind, res.result_kind);
				check_field("payload_value", want.payload_value, res.payload_value);
				check_field("payload_position", want.payload_position, res.payload_position);
				check_field("frame_good", want.frame_good, res.frame_good);
				check_field("error_code", want.error_code, res.error_code);
				check_field("message_id", want.message_id, res.message_id);
				check_field("command_code", want.command_code, res.command_code);
				check_field("payload_length", want.payload_length, res.payload_length);
				check_field("first_payload", want.first_payload, res.first_payload);
				check_field("has_first_payload", want.has_first_payload,
					res.has_first_payload);
			end
			if (res.result_kind === xcfp_pkg::KIND_VERDICT &&
					res.error_code <= xcfp_pkg::ERR_CHECKSUM)
				verdicts_seen[res.error_code]++;
			else if (res.result_kind === xcfp_pkg::KIND_PAYLOAD)
				payloads_seen++;
		end
		if ((res.valid === 1'b1 && res.ready === 1'b1) ||
				(rx.valid === 1'b1 && rx.ready === 1'b1) ||
				(cfg.valid === 1'b1 && cfg.ready === 1'b1))
			stall_cycles = 0;
		else
			stall_cycles++;
		if (stall_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog: no transfer for %0d cycles", stall_cycles);
			$display("xor_checked_frame_parser test failed");
			$finish;
		end
	end

	initial begin
		res.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_off_len > 0) begin
				res.ready <= 1'b0;
				hold_off_len--;
			end else begin
				res.ready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	task automatic send_byte(input byte_t b, input logic last);
		logic took;
		while ($urandom_range(99) < send_idle_pct) begin
			rx.valid <= 1'b0;
			@(posedge clk);
		end
		rx.valid     <= 1'b1;
		rx.data_byte <= b;
		rx.last_byte <= last;
		do begin
			@(negedge clk);
			took = rx.ready;
			@(posedge clk);
		end while (took !== 1'b1);
		parse_rx_byte(b, last);
		bytes_sent++;
	endtask

	task automatic send_buffer();
		foreach (frame_bytes[i])
			send_byte(frame_bytes[i], i == frame_bytes.size() - 1);
	endtask

	task automatic assemble_frame(input byte_t sob, input byte_t id, input byte_t cmd,
			input byte_t len);
		byte_t sum;
		frame_bytes = {};
		frame_bytes = {frame_bytes, sob};
		frame_bytes = {frame_bytes, id};
		frame_bytes = {frame_bytes, cmd};
		frame_bytes = {frame_bytes, len};
		repeat (len)
			frame_bytes = {frame_bytes, byte_t'($urandom)};
		sum = '0;
		foreach (frame_bytes[i])
			sum ^= frame_bytes[i];
		frame_bytes = {frame_bytes, sum};
	endtask

	task automatic wait_idle();
		rx.valid <= 1'b0;
		while (outputs_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_start_byte(input byte_t value);
		logic took;
		wait_idle();
		cfg.valid      <= 1'b1;
		cfg.start_byte <= value;
		do begin
			@(negedge clk);
			took = cfg.ready;
			@(posedge clk);
		end while (took !== 1'b1);
		cfg.valid   <= 1'b0;
		p_start_cfg = value;
	endtask

	task automatic send_random_buffer();
		int unsigned pick;
		int unsigned len;
		int unsigned cut;
		pick = $urandom_range(99);
		len  = ($urandom_range(7) == 0) ? $urandom_range(48) : $urandom_range(6);
		assemble_frame(p_start_cfg, byte_t'($urandom), byte_t'($urandom), byte_t'(len));
		if (pick < 8) begin
			frame_bytes[0] ^= byte_t'($urandom_range(255, 1));
		end else if (pick < 16) begin
			frame_bytes[frame_bytes.size() - 1] ^= byte_t'($urandom_range(255, 1));
		end else if (pick < 22) begin
			cut = $urandom_range(frame_bytes.size() - 1, 1);
			repeat (cut) void'(frame_bytes.pop_back());
		end else if (pick < 28) begin
			repeat ($urandom_range(4, 1)) frame_bytes = {frame_bytes, byte_t'($urandom)};
		end else if (pick < 34) begin
			frame_bytes = {};
			repeat ($urandom_range(10, 1)) frame_bytes = {frame_bytes, byte_t'($urandom)};
		end
		send_buffer();
	endtask

	task automatic test_short_buffers();
		frame_bytes = {8'hFF};
		send_buffer();
		assemble_frame(xcfp_pkg::START_BYTE_RESET, 8'h12, 8'h34, 8'h05);
		frame_bytes = frame_bytes[0:3];
		send_buffer();
	endtask

	task automatic test_minimal_frames();
		assemble_frame(xcfp_pkg::START_BYTE_RESET, 8'hFF, 8'h00, 8'h00);
		send_buffer();
		assemble_frame(xcfp_pkg::START_BYTE_RESET, 8'h00, 8'hFF, 8'h00);
		frame_bytes[4] ^= 8'h80;
		send_buffer();
	endtask

	task automatic test_payload_errors();
		assemble_frame(xcfp_pkg::START_BYTE_RESET, 8'h01, 8'h02, 8'h03);
		frame_bytes = frame_bytes[0:5];
		send_buffer();
		assemble_frame(8'h55, 8'hA5, 8'h5A, 8'h01);
		send_buffer();
	endtask

	task automatic test_start_byte_config();
		byte_t settings[4];
		settings = '{8'h00, 8'hFF, byte_t'($urandom), xcfp_pkg::START_BYTE_RESET};
		foreach (settings[i]) begin
			write_start_byte(settings[i]);
			assemble_frame(settings[i], byte_t'($urandom), byte_t'($urandom), 8'h02);
			send_buffer();
			assemble_frame(settings[i] ^ 8'h01, byte_t'($urandom), byte_t'($urandom), 8'h01);
			send_buffer();
		end
	endtask

	task automatic test_random_traffic(input int unsigned send_pct, input int unsigned recv_pct,
			input int unsigned n_bytes, input byte_t sob);
		int unsigned stop_at;
		write_start_byte(sob);
		send_idle_pct = send_pct;
		recv_idle_pct = recv_pct;
		stop_at = bytes_sent + n_bytes;
		while (bytes_sent < stop_at)
			send_random_buffer();
	endtask

	task automatic test_backpressure();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		assemble_frame(p_start_cfg, byte_t'($urandom), byte_t'($urandom), 8'd40);
		hold_off_len = HOLD_OFF_LEN;
		send_buffer();
	endtask

	task automatic test_long_buffer();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		assemble_frame(p_start_cfg, byte_t'($urandom), byte_t'($urandom), 8'd255);
		while (frame_bytes.size() < 300)
			frame_bytes = {frame_bytes, byte_t'($urandom)};
		send_buffer();
	endtask

	initial begin
		rx.valid       = 1'b0;
		rx.data_byte   = '0;
		rx.last_byte   = 1'b0;
		cfg.valid      = 1'b0;
		cfg.start_byte = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_idle_pct = 16;
		recv_idle_pct = 65;
		test_short_buffers();
		test_minimal_frames();
		test_payload_errors();
		test_start_byte_config();
		test_random_traffic(16, 65, 60, xcfp_pkg::START_BYTE_RESET);
		test_random_traffic(65, 16, 60, byte_t'($urandom));
		test_random_traffic(0, 0, 60, xcfp_pkg::START_BYTE_RESET);
		test_backpressure();
		test_long_buffer();

		wait_idle();
		$display("sent %0d bytes, checked %0d payload transfers", bytes_sent, payloads_seen);
		$display("verdicts ok/short/start/length/checksum: %0d/%0d/%0d/%0d/%0d",
			verdicts_seen[xcfp_pkg::ERR_OK], verdicts_seen[xcfp_pkg::ERR_SHORT],
			verdicts_seen[xcfp_pkg::ERR_START], verdicts_seen[xcfp_pkg::ERR_LENGTH],
			verdicts_seen[xcfp_pkg::ERR_CHECKSUM]);
		if (mismatches == 0)
			$display("xor_checked_frame_parser test passed");
		else
			$display("xor_checked_frame_parser test failed");
		$finish;
	end

endmodule
